// ===== hw/rtl/msi_pkg.sv =====
// ----------------------------------------------------------------------------
// msi_pkg
// shared types and codes for the msi snooping cache controller
// ----------------------------------------------------------------------------
package msi_pkg;

    typedef enum logic [1:0] {
        FUNC_PR_RD  = 2'd0,
        FUNC_PR_WR  = 2'd1,
        FUNC_BUS_RD = 2'd2,
        FUNC_BUS_RDX = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        BREQ_NONE  = 2'd0,
        BREQ_BUSRD = 2'd1,
        BREQ_BUSRDX = 2'd2
    } t_breq;

    localparam logic [1:0] ST_INV = 2'd0;
    localparam logic [1:0] ST_SHR = 2'd1;
    localparam logic [1:0] ST_MOD = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_OUT
    } t_ctl_state;

    typedef struct packed {
        logic       hit;
        logic [1:0] bus_request;
        logic       victim_writeback;
        logic       memory_access;
        logic       flush;
        logic       intervention;
        logic       invalidation;
    } t_result;

endpackage

// ===== hw/rtl/msi_if.sv =====
// ----------------------------------------------------------------------------
// msi_req_if / msi_rsp_if
// valid/ready channels for items into and out of the controller
// ----------------------------------------------------------------------------
interface msi_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] addr;
    modport source (output valid, output func, output addr, input ready);
    modport sink   (input valid, input func, input addr, output ready);
endinterface

interface msi_rsp_if;
    logic       valid;
    logic       ready;
    logic       hit;
    logic [1:0] bus_request;
    logic       victim_writeback;
    logic       memory_access;
    logic       flush;
    logic       intervention;
    logic       invalidation;
    modport source (output valid, output hit, output bus_request, output victim_writeback,
                    output memory_access, output flush, output intervention,
                    output invalidation, input ready);
    modport sink   (input valid, input hit, input bus_request, input victim_writeback,
                    input memory_access, input flush, input intervention,
                    input invalidation, output ready);
endinterface

// ===== hw/rtl/msi_set_mem.sv =====
// ----------------------------------------------------------------------------
// msi_set_mem
// one row per set holding tag and stamp of every way, registered read
// ----------------------------------------------------------------------------
module msi_set_mem #(
    parameter int SETS   = 256,
    parameter int WAYS   = 4,
    parameter int TAG_W  = 18
) (
    input  logic                              i_clk,
    input  logic [$clog2(SETS+1)-1:0]         i_rd_set,
    output logic [WAYS-1:0][TAG_W-1:0]        o_rd_tag,
    output logic [WAYS-1:0][31:0]             o_rd_stamp,
    input  logic                              i_wr_en,
    input  logic [$clog2(SETS+1)-1:0]         i_wr_set,
    input  logic [WAYS-1:0][TAG_W-1:0]        i_wr_tag,
    input  logic [WAYS-1:0][31:0]             i_wr_stamp
);
    localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;

    logic [WAYS-1:0][TAG_W-1:0] r_tag_mem   [SETS];
    logic [WAYS-1:0][31:0]      r_stamp_mem [SETS];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_tag_mem[i_wr_set[SW-1:0]]   <= i_wr_tag;
            r_stamp_mem[i_wr_set[SW-1:0]] <= i_wr_stamp;
        end
        o_rd_tag   <= r_tag_mem[i_rd_set[SW-1:0]];
        o_rd_stamp <= r_stamp_mem[i_rd_set[SW-1:0]];
    end
endmodule

// ===== hw/rtl/msi_state_mem.sv =====
// ----------------------------------------------------------------------------
// msi_state_mem
// per-set line states with a clearing pass after reset
// ----------------------------------------------------------------------------
module msi_state_mem #(
    parameter int SETS = 256,
    parameter int WAYS = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [$clog2(SETS+1)-1:0]      i_rd_set,
    output logic [WAYS-1:0][1:0]           o_rd_state,
    input  logic                           i_wr_en,
    input  logic [$clog2(SETS+1)-1:0]      i_wr_set,
    input  logic [WAYS-1:0][1:0]           i_wr_state,
    output logic                           o_busy
);
    import msi_pkg::*;
    localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int CW = $clog2(SETS+1);

    logic [WAYS-1:0][1:0] r_mem [SETS];
    logic [CW-1:0]        r_clr;
    logic [CW-1:0]        n_clr;

    assign o_busy = (r_clr != CW'(SETS));
    assign n_clr  = o_busy ? r_clr + CW'(1) : r_clr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else begin
            r_clr <= n_clr;
        end
    end

    // clearing sweep has priority over functional writes
    always_ff @(posedge i_clk) begin
        if (o_busy) begin
            r_mem[r_clr[SW-1:0]] <= {WAYS{ST_INV}};
        end else if (i_wr_en) begin
            r_mem[i_wr_set[SW-1:0]] <= i_wr_state;
        end
        o_rd_state <= r_mem[i_rd_set[SW-1:0]];
    end
endmodule

// ===== hw/rtl/msi_snooping_cache_controller_unit.sv =====
// ----------------------------------------------------------------------------
// msi_snooping_cache_controller_unit
// msi snooping tag controller, set-associative, lru replacement
// ----------------------------------------------------------------------------
// For each item (func, addr) the set row is read from the state and
// tag/stamp memories (registered read), all ways are compared and the
// victim chosen in parallel while the updated row is written back, and
// the result then sits in an output register until taken. One item is in
// flight at a time, so the set read-modify-write never overlaps. After reset
// a clearing pass over all SETS sets marks every line invalid; no item is
// accepted during it. Stamps use a wrapping 32-bit access counter; the victim
// is the first invalid way, else the smallest stamp, highest way on ties.
module msi_snooping_cache_controller_unit #(
    parameter int SETS        = 256,
    parameter int WAYS        = 4,
    parameter int BLOCK_BYTES = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    msi_req_if.sink    i_req,
    msi_rsp_if.source  o_rsp
);
    import msi_pkg::*;

    localparam int OFF_W = $clog2(BLOCK_BYTES);
    localparam int SET_W = $clog2(SETS);
    localparam int TAG_W = 32 - OFF_W - SET_W;
    localparam int CW    = $clog2(SETS+1);
    localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;

    t_ctl_state r_st, n_st;
    logic [1:0]       r_func;
    logic [TAG_W-1:0] r_tag;
    logic [CW-1:0]    r_set;
    logic [31:0]      r_count, n_count;
    t_result          r_res, n_res;

    logic [WAYS-1:0][TAG_W-1:0] rd_tag, wr_tag;
    logic [WAYS-1:0][31:0]      rd_stamp, wr_stamp;
    logic [WAYS-1:0][1:0]       rd_state, wr_state;
    logic                       clr_busy, wr_en;
    logic [CW-1:0]              rd_set;
    logic [OFF_W+SET_W-1:0]     low_bits;

    // set index from the incoming address
    always_comb begin
        low_bits = i_req.addr[OFF_W+SET_W-1:0];
        rd_set   = '0;
        if (SET_W > 0) rd_set = CW'(low_bits >> OFF_W);
    end

    msi_set_mem #(.SETS(SETS), .WAYS(WAYS), .TAG_W(TAG_W)) u_set_mem (
        .i_clk(i_clk), .i_rd_set(rd_set), .o_rd_tag(rd_tag), .o_rd_stamp(rd_stamp),
        .i_wr_en(wr_en), .i_wr_set(r_set), .i_wr_tag(wr_tag), .i_wr_stamp(wr_stamp)
    );

    msi_state_mem #(.SETS(SETS), .WAYS(WAYS)) u_state_mem (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_rd_set(rd_set), .o_rd_state(rd_state),
        .i_wr_en(wr_en), .i_wr_set(r_set), .i_wr_state(wr_state), .o_busy(clr_busy)
    );

    // control fsm: next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (i_req.valid && i_req.ready) n_st = S_LOOK;
            S_LOOK: n_st = S_OUT;
            S_OUT:  if (o_rsp.ready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // control fsm: outputs
    always_comb begin
        i_req.ready = (r_st == S_IDLE) && !clr_busy;
        o_rsp.valid = (r_st == S_OUT);
        wr_en       = (r_st == S_LOOK);
    end

    // lookup, victim choice and row update
    logic [WAYS-1:0] match;
    logic            found, any_inv, wr;
    logic [WW-1:0]   hit_way, inv_way, lru_way, vic_way, k;
    logic [31:0]     lo;

    always_comb begin
        match   = '0;
        found   = 1'b0;
        hit_way = '0;
        any_inv = 1'b0;
        inv_way = '0;
        lru_way = '0;
        lo      = 32'hFFFF_FFFF;
        for (int w = 0; w < WAYS; w++) begin
            match[w] = (rd_state[w] != ST_INV) && (rd_tag[w] == r_tag);
        end
        for (int w = WAYS-1; w >= 0; w--) begin
            if (match[w]) begin
                found   = 1'b1;
                hit_way = WW'(w);
            end
            if (rd_state[w] == ST_INV) begin
                any_inv = 1'b1;
                inv_way = WW'(w);
            end
        end
        for (int w = 0; w < WAYS; w++) begin
            if (rd_stamp[w] <= lo) begin
                lo      = rd_stamp[w];
                lru_way = WW'(w);
            end
        end
        vic_way = any_inv ? inv_way : lru_way;

        wr       = (r_func == FUNC_PR_WR);
        wr_tag   = rd_tag;
        wr_stamp = rd_stamp;
        wr_state = rd_state;
        n_res    = r_res;
        n_count  = r_count;
        k        = found ? hit_way : vic_way;

        if (r_st == S_LOOK) begin
            n_res = '0;
            if (r_func == FUNC_PR_RD || r_func == FUNC_PR_WR) begin
                n_count     = r_count + 32'd1;
                wr_stamp[k] = n_count;
                if (!found) begin
                    n_res.bus_request      = wr ? BREQ_BUSRDX : BREQ_BUSRD;
                    n_res.memory_access    = 1'b1;
                    n_res.victim_writeback = (rd_state[k] == ST_MOD);
                    wr_tag[k]   = r_tag;
                    wr_state[k] = wr ? ST_MOD : ST_SHR;
                end else begin
                    n_res.hit = 1'b1;
                    if (wr) begin
                        if (rd_state[k] == ST_SHR) begin
                            n_res.bus_request   = BREQ_BUSRDX;
                            n_res.memory_access = 1'b1;
                        end
                        wr_state[k] = ST_MOD;
                    end
                end
            end else if (found) begin
                n_res.hit = 1'b1;
                if (r_func == FUNC_BUS_RD) begin
                    if (rd_state[k] == ST_MOD) begin
                        wr_state[k]          = ST_SHR;
                        n_res.intervention   = 1'b1;
                        n_res.memory_access  = 1'b1;
                        n_res.flush          = 1'b1;
                    end
                end else begin
                    if (rd_state[k] == ST_MOD) begin
                        n_res.flush         = 1'b1;
                        n_res.memory_access = 1'b1;
                    end
                    wr_state[k]        = ST_INV;
                    n_res.invalidation = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_count <= '0;
        end else begin
            r_st    <= n_st;
            r_count <= n_count;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_func <= i_req.func;
            r_tag  <= i_req.addr[31 -: TAG_W];
            r_set  <= rd_set;
        end
        r_res <= n_res;
    end

    assign o_rsp.hit              = r_res.hit;
    assign o_rsp.bus_request      = r_res.bus_request;
    assign o_rsp.victim_writeback = r_res.victim_writeback;
    assign o_rsp.memory_access    = r_res.memory_access;
    assign o_rsp.flush            = r_res.flush;
    assign o_rsp.intervention     = r_res.intervention;
    assign o_rsp.invalidation     = r_res.invalidation;
endmodule

// ===== hw/rtl/msi_checker.sv =====
// ----------------------------------------------------------------------------
// msi_checker
// port-level checks on the controller, bound to the top level
// ----------------------------------------------------------------------------
module msi_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       hit,
    input logic [1:0] bus_request,
    input logic       victim_writeback,
    input logic       flush,
    input logic       intervention,
    input logic       invalidation
);
    import msi_pkg::*;

    // response must hold while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(hit) && $stable(bus_request))
        else $error("result changed while stalled");

    // one item in flight: no accept while a result waits
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> !req_ready)
        else $error("input taken while result pending");

    // processor and snoop flags never mix
    a_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && (bus_request != BREQ_NONE || victim_writeback) |->
        !flush && !intervention && !invalidation)
        else $error("processor and snoop flags together");

    // a writeback only on a miss
    a_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && victim_writeback |-> !hit)
        else $error("writeback on hit");
endmodule

bind msi_snooping_cache_controller_unit msi_checker u_msi_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .req_valid(i_req.valid), .req_ready(i_req.ready),
    .rsp_valid(o_rsp.valid), .rsp_ready(o_rsp.ready),
    .hit(o_rsp.hit), .bus_request(o_rsp.bus_request),
    .victim_writeback(o_rsp.victim_writeback), .flush(o_rsp.flush),
    .intervention(o_rsp.intervention), .invalidation(o_rsp.invalidation)
);
